// ----- src/text_console_writer_core_assert.svh -----
// Assertion macros shared by the checker of the text console writer.
`ifndef TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_CORE_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/tcw_pkg.sv -----
// Types and constants shared by the text console writer modules.
`timescale 1ns / 1ps
package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'd32;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [10:0] cell_index;
  } request_t;

  typedef struct packed {
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
    logic [10:0] cursor_pos;
    logic        scrolled;
  } result_t;

  typedef struct packed {
    logic load;
    logic init_step;
    logic exec;
    logic scroll_step;
    logic fill_step;
    logic clear_step;
    logic finish;
  } ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       wrap;
    logic       init_last;
    logic       scroll_last;
    logic       fill_last;
    logic       clear_last;
  } sts_t;

endpackage

// ----- src/tcw_ctrl.sv -----
// Controller state machine of the text console writer.
`timescale 1ns / 1ps
module tcw_ctrl
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  sts_t sts,
  output ctl_t ctl,
  output logic busy,
  output logic done
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_SCROLL,
    S_FILL,
    S_CLEAR,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    ctl.load        = start && (state == S_IDLE);
    ctl.init_step   = (state == S_INIT);
    ctl.exec        = (state == S_EXEC);
    ctl.scroll_step = (state == S_SCROLL);
    ctl.fill_step   = (state == S_FILL);
    ctl.clear_step  = (state == S_CLEAR);
    ctl.finish      = (state == S_FIN);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT: begin
        if (sts.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        priority if (sts.op == OP_PUT && sts.wrap) state_next = S_SCROLL;
        else if (sts.op == OP_CLEAR) state_next = S_CLEAR;
        else state_next = S_FIN;
      end
      S_SCROLL: begin
        if (sts.scroll_last) state_next = S_FILL;
      end
      S_FILL: begin
        if (sts.fill_last) state_next = S_FIN;
      end
      S_CLEAR: begin
        if (sts.clear_last) state_next = S_FIN;
      end
      S_FIN: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != S_IDLE);
      done  <= (state == S_FIN);
    end
  end

endmodule

// ----- src/tcw_datapath.sv -----
// Datapath of the text console writer: screen memory, cursor and sweep counter.
`timescale 1ns / 1ps
module tcw_datapath
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic     clk,
  input  logic     rst,
  input  ctl_t     ctl,
  input  request_t request,
  output sts_t     sts,
  output result_t  result
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int MOVE   = CELLS - COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int COL_W  = $clog2(COLUMNS);

  logic [15:0]       mem [CELLS];
  logic [15:0]       rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr_mux;
  logic [15:0]       wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  request_t          req_q;
  logic [CNT_W-1:0]  cnt;
  logic              pend;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] cursor;
  logic [COL_W-1:0]  col;
  logic              scrolled;
  logic              rd_ok;

  logic              newline;
  logic              in_range;
  logic [CNT_W-1:0]  put_next;
  logic [ADDR_W-1:0] cursor_put;
  logic [COL_W-1:0]  col_put;

  always_comb begin
    newline  = (req_q.char_code == NEWLINE_CODE);
    in_range = (32'(req_q.cell_index) < 32'(CELLS));
    if (newline) begin
      put_next = CNT_W'(cursor) - CNT_W'(col) + CNT_W'(COLUMNS);
    end else begin
      put_next = CNT_W'(cursor) + CNT_W'(1);
    end
    sts.wrap = (put_next == CNT_W'(CELLS));
    if (sts.wrap) begin
      cursor_put = ADDR_W'(put_next - CNT_W'(COLUMNS));
    end else begin
      cursor_put = ADDR_W'(put_next);
    end
    if (newline || col == COL_W'(COLUMNS - 1)) begin
      col_put = '0;
    end else begin
      col_put = col + COL_W'(1);
    end
    sts.op          = req_q.opcode;
    sts.init_last   = (cnt == CNT_W'(CELLS - 1));
    sts.scroll_last = (cnt == CNT_W'(MOVE));
    sts.fill_last   = (cnt == CNT_W'(CELLS - 1));
    sts.clear_last  = (cnt == CNT_W'(CELLS));
  end

  always_comb begin
    we        = 1'b0;
    waddr_mux = cnt[ADDR_W-1:0];
    wdata     = '0;
    priority if (ctl.init_step) begin
      we = 1'b1;
    end else if (ctl.exec) begin
      we        = (req_q.opcode == OP_PUT) && !newline;
      waddr_mux = cursor;
      wdata     = {req_q.attribute, req_q.char_code};
    end else if (ctl.scroll_step) begin
      we        = pend;
      waddr_mux = waddr;
      wdata     = rdata;
    end else if (ctl.clear_step) begin
      we        = pend;
      waddr_mux = waddr;
      wdata     = {rdata[15:8], SPACE_CODE};
    end else if (ctl.fill_step) begin
      we    = 1'b1;
      wdata = {req_q.attribute, SPACE_CODE};
    end else begin
      we = 1'b0;
    end
  end

  always_comb begin
    re    = 1'b0;
    raddr = cnt[ADDR_W-1:0];
    priority if (ctl.exec) begin
      re    = (req_q.opcode == OP_READ) && in_range;
      raddr = ADDR_W'(req_q.cell_index);
    end else if (ctl.scroll_step) begin
      re    = !sts.scroll_last;
      raddr = ADDR_W'(cnt + CNT_W'(COLUMNS));
    end else if (ctl.clear_step) begin
      re = !sts.clear_last;
    end else begin
      re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr_mux] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      pend     <= 1'b0;
      cursor   <= '0;
      col      <= '0;
      scrolled <= 1'b0;
    end else begin
      if (ctl.load) begin
        scrolled <= 1'b0;
      end
      if (ctl.exec) begin
        cnt  <= '0;
        pend <= 1'b0;
        if (req_q.opcode == OP_PUT) begin
          cursor   <= cursor_put;
          col      <= col_put;
          scrolled <= sts.wrap;
        end else if (req_q.opcode == OP_CLEAR) begin
          cursor <= '0;
          col    <= '0;
        end
      end
      if (ctl.init_step || ctl.fill_step) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (ctl.scroll_step) begin
        pend <= !sts.scroll_last;
        if (!sts.scroll_last) cnt <= cnt + CNT_W'(1);
      end
      if (ctl.clear_step) begin
        pend <= !sts.clear_last;
        if (!sts.clear_last) cnt <= cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) req_q <= request;
    if (ctl.scroll_step || ctl.clear_step) waddr <= cnt[ADDR_W-1:0];
    if (ctl.exec) rd_ok <= (req_q.opcode == OP_READ) && in_range;
    if (ctl.finish) begin
      result.cell_char  <= rd_ok ? rdata[7:0] : 8'd0;
      result.cell_attr  <= rd_ok ? rdata[15:8] : 8'd0;
      result.cursor_pos <= 11'(cursor);
      result.scrolled   <= scrolled;
    end
  end

endmodule

// ----- src/text_console_writer_core.sv -----
// Top level of the text console writer: a text screen with cursor and scroll.
//
// A transaction is accepted at a rising edge with start high and busy low; the
// request struct carries opcode, character, attribute and cell index. Each
// transaction yields one result, shown on result for exactly one cycle while
// done is high. The receiver cannot stall, so the result is taken in that cycle.
// A put that scrolls first moves the rows up and then blanks the bottom row; a
// clear sweeps every cell. The row move and the clear use one read and one
// write of the single screen memory per cell, which sets the throughput; busy
// stays high for the whole transaction.
// After a synchronous reset the block zeroes the screen memory, one cell a
// cycle, with busy high and the cursor at home, then accepts transactions.
`timescale 1ns / 1ps
module text_console_writer_core
  import tcw_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  ctl_t ctl;
  sts_t sts;

  tcw_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .request (request),
    .sts     (sts),
    .result  (result)
  );

endmodule

// ----- src/tcw_checker.sv -----
// Port-level checker for the text console writer and its bind statement.
`timescale 1ns / 1ps
`include "text_console_writer_core_assert.svh"
module tcw_checker
  import tcw_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    done,
  input result_t result
);

  `TCW_ASSERT_SAME(a_done_idle, done, !busy, "Result shown while the block is busy.")
  `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Accepted transaction did not raise busy.")
  `TCW_ASSERT_NEXT(a_done_single, done, !done, "Result strobe lasted more than one cycle.")
  `TCW_ASSERT_SAME(a_scroll_no_cell, done && result.scrolled,
    result.cell_char == 8'd0 && result.cell_attr == 8'd0, "Scrolling result carries cell data.")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
